// ----- src/hsvc_pkg.sv -----
// Shared constants and stage payload types for the HSV to RGB converter.
package hsvc_pkg;

  localparam logic [8:0]  HUE_TURN   = 9'd360;
  localparam logic [8:0]  SECTOR_DEG = 9'd60;
  localparam logic [6:0]  PCT_MAX    = 7'd100;
  // 100 * 60: full-scale numerator factor
  localparam logic [12:0] K_FULL     = 13'd6000;
  // 255 / 600000 reduces to 17 / 40000
  localparam logic [23:0] CH_DIV     = 24'd40000;
  // floor(2^32 / 40000)
  localparam logic [16:0] RECIP      = 17'd107374;

  typedef enum logic [2:0] {
    SEC_0 = 3'd0,
    SEC_1 = 3'd1,
    SEC_2 = 3'd2,
    SEC_3 = 3'd3,
    SEC_4 = 3'd4,
    SEC_5 = 3'd5
  } sector_t;

  typedef struct packed {
    sector_t     sector;
    logic [5:0]  rem;
    logic [6:0]  sat;
    logic [6:0]  val;
  } dec_t;

  typedef struct packed {
    sector_t     sector;
    logic [6:0]  val;
    logic [12:0] kp;
    logic [12:0] kq;
    logic [12:0] kt;
  } coef_t;

  typedef logic [2:0][19:0] num3_t;
  typedef logic [2:0][7:0]  chan3_t;

endpackage

// ----- src/hsvc_decode.sv -----
// Stage 1: clamp inputs, split hue into sector and offset.
module hsvc_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [8:0]        hue,
  input  logic [6:0]        saturation,
  input  logic [6:0]        brightness,
  output logic              out_valid,
  input  logic              out_ready,
  output hsvc_pkg::dec_t    out_data
);

  logic           valid_r;
  hsvc_pkg::dec_t data_r, data_nxt;
  logic [8:0]     hue_c;
  logic [8:0]     base;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    hue_c = (hue >= hsvc_pkg::HUE_TURN) ? 9'd0 : hue;
    if (hue_c >= 9'(5 * hsvc_pkg::SECTOR_DEG)) begin
      data_nxt.sector = hsvc_pkg::SEC_5;
      base = 9'(5 * hsvc_pkg::SECTOR_DEG);
    end else if (hue_c >= 9'(4 * hsvc_pkg::SECTOR_DEG)) begin
      data_nxt.sector = hsvc_pkg::SEC_4;
      base = 9'(4 * hsvc_pkg::SECTOR_DEG);
    end else if (hue_c >= 9'(3 * hsvc_pkg::SECTOR_DEG)) begin
      data_nxt.sector = hsvc_pkg::SEC_3;
      base = 9'(3 * hsvc_pkg::SECTOR_DEG);
    end else if (hue_c >= 9'(2 * hsvc_pkg::SECTOR_DEG)) begin
      data_nxt.sector = hsvc_pkg::SEC_2;
      base = 9'(2 * hsvc_pkg::SECTOR_DEG);
    end else if (hue_c >= hsvc_pkg::SECTOR_DEG) begin
      data_nxt.sector = hsvc_pkg::SEC_1;
      base = hsvc_pkg::SECTOR_DEG;
    end else begin
      data_nxt.sector = hsvc_pkg::SEC_0;
      base = 9'd0;
    end
    data_nxt.rem = 6'(hue_c - base);
    data_nxt.sat = (saturation > hsvc_pkg::PCT_MAX) ? hsvc_pkg::PCT_MAX : saturation;
    data_nxt.val = (brightness > hsvc_pkg::PCT_MAX) ? hsvc_pkg::PCT_MAX : brightness;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ----- src/hsvc_coef.sv -----
// Stage 2: per-sector ramp factors p, q, t scaled by 6000.
module hsvc_coef (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  hsvc_pkg::dec_t    in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output hsvc_pkg::coef_t   out_data
);

  logic            valid_r;
  hsvc_pkg::coef_t data_r, data_nxt;
  logic [12:0]     s_rem;
  logic [12:0]     s_rem_n;
  logic [5:0]      rem_n;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    rem_n   = 6'(hsvc_pkg::SECTOR_DEG) - in_data.rem;
    s_rem   = 13'(in_data.sat) * 13'(in_data.rem);
    s_rem_n = 13'(in_data.sat) * 13'(rem_n);
    data_nxt.sector = in_data.sector;
    data_nxt.val    = in_data.val;
    data_nxt.kp     = 13'(hsvc_pkg::PCT_MAX - in_data.sat) * 13'(hsvc_pkg::SECTOR_DEG);
    data_nxt.kq     = hsvc_pkg::K_FULL - s_rem;
    data_nxt.kt     = hsvc_pkg::K_FULL - s_rem_n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ----- src/hsvc_scale.sv -----
// Stage 3: sector routing onto r/g/b and scaling by value.
module hsvc_scale (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  hsvc_pkg::coef_t   in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output hsvc_pkg::num3_t   out_num
);

  logic            valid_r;
  hsvc_pkg::num3_t num_r, num_nxt;
  logic [2:0][12:0] k;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_num   = num_r;

  // lane 0 red, lane 1 green, lane 2 blue
  always_comb begin
    case (in_data.sector)
      hsvc_pkg::SEC_0: k = {in_data.kp, in_data.kt, hsvc_pkg::K_FULL};
      hsvc_pkg::SEC_1: k = {in_data.kp, hsvc_pkg::K_FULL, in_data.kq};
      hsvc_pkg::SEC_2: k = {in_data.kt, hsvc_pkg::K_FULL, in_data.kp};
      hsvc_pkg::SEC_3: k = {hsvc_pkg::K_FULL, in_data.kq, in_data.kp};
      hsvc_pkg::SEC_4: k = {hsvc_pkg::K_FULL, in_data.kp, in_data.kt};
      default:         k = {in_data.kq, in_data.kp, hsvc_pkg::K_FULL};
    endcase
    for (int i = 0; i < 3; i++) begin
      num_nxt[i] = 20'(in_data.val) * 20'(k[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      num_r <= num_nxt;
    end
  end

endmodule

// ----- src/hsvc_chan.sv -----
// Stages 4-5: floor(17 * x / 40000) per lane by reciprocal multiply and correction.
module hsvc_chan (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  hsvc_pkg::num3_t   in_num,
  output logic              out_valid,
  input  logic              out_ready,
  output hsvc_pkg::chan3_t  out_chan
);

  logic              valid_a_r;
  logic              valid_b_r;
  logic              ready_a;
  logic              ready_b;
  logic [2:0][23:0]  y_nxt;
  logic [2:0][23:0]  y_r;
  logic [2:0][40:0]  prod;
  logic [2:0][7:0]   q0_nxt;
  logic [2:0][7:0]   q0_r;
  logic [2:0][23:0]  rem_w;
  hsvc_pkg::chan3_t  chan_nxt;
  hsvc_pkg::chan3_t  chan_r;

  assign ready_b   = !valid_b_r || out_ready;
  assign ready_a   = !valid_a_r || ready_b;
  assign in_ready  = ready_a;
  assign out_valid = valid_b_r;
  assign out_chan  = chan_r;

  // estimate is exact or one low, since y < 2^24
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      y_nxt[i]  = {in_num[i], 4'b0000} + 24'(in_num[i]);
      prod[i]   = 41'(y_nxt[i]) * 41'(hsvc_pkg::RECIP);
      q0_nxt[i] = prod[i][39:32];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rem_w[i]    = y_r[i] - 24'(q0_r[i]) * hsvc_pkg::CH_DIV;
      chan_nxt[i] = q0_r[i] + 8'(rem_w[i] >= hsvc_pkg::CH_DIV);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
      valid_b_r <= 1'b0;
    end else begin
      if (ready_a) begin
        valid_a_r <= in_valid;
      end
      if (ready_b) begin
        valid_b_r <= valid_a_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a) begin
      y_r  <= y_nxt;
      q0_r <= q0_nxt;
    end
    if (ready_b) begin
      chan_r <= chan_nxt;
    end
  end

`ifndef SYNTHESIS
  a_est_within_one: assert property (@(posedge clk) disable iff (!rst_n)
    valid_a_r |-> (rem_w[0] < 2 * hsvc_pkg::CH_DIV) && (rem_w[1] < 2 * hsvc_pkg::CH_DIV)
                  && (rem_w[2] < 2 * hsvc_pkg::CH_DIV))
    else $error("reciprocal estimate off by more than one");

  a_handoff: assert property (@(posedge clk) disable iff (!rst_n)
    valid_a_r && ready_b |=> valid_b_r)
    else $error("item lost between correction stages");
`endif

endmodule

// ----- src/hsv_to_rgb_convert.sv -----
// HSV to RGB converter: top level, five-stage pipeline.
// Throughput: one transaction per cycle unless the output stalls; any stage with a
// free or draining slot takes new data, so bubbles close up while the output is stalled.
// The five registered stages are decode, coefficient multiply, value multiply,
// reciprocal multiply and remainder correction.
// Reset (rst_n low, synchronous) clears only the per-stage valid bits.
module hsv_to_rgb_convert (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // hue[8:0], saturation[15:9], brightness[22:16], pad[23]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // red[7:0], green[15:8], blue[23:16]
);

  // stage handshakes
  logic             dec_valid;
  logic             dec_ready;
  logic             coef_valid;
  logic             coef_ready;
  logic             scl_valid;
  logic             scl_ready;
  hsvc_pkg::dec_t   dec_data;
  hsvc_pkg::coef_t  coef_data;
  hsvc_pkg::num3_t  scl_num;
  hsvc_pkg::chan3_t chan;

  // Stage 1: hue -> sector/offset, clamp S and V to 100
  hsvc_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .hue        (in_tdata[8:0]),
    .saturation (in_tdata[15:9]),
    .brightness (in_tdata[22:16]),
    .out_valid  (dec_valid),
    .out_ready  (dec_ready),
    .out_data   (dec_data)
  );

  // Stage 2: p, q, t factors over 6000
  hsvc_coef u_coef (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dec_valid),
    .in_ready  (dec_ready),
    .in_data   (dec_data),
    .out_valid (coef_valid),
    .out_ready (coef_ready),
    .out_data  (coef_data)
  );

  // Stage 3: six-sector routing, times V -> numerators over 600000
  hsvc_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (coef_valid),
    .in_ready  (coef_ready),
    .in_data   (coef_data),
    .out_valid (scl_valid),
    .out_ready (scl_ready),
    .out_num   (scl_num)
  );

  // Stages 4-5: exact floor(255 * x / 600000); last register is the output register
  hsvc_chan u_chan (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (scl_valid),
    .in_ready  (scl_ready),
    .in_num    (scl_num),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_chan  (chan)
  );

  assign out_tdata = {chan[2], chan[1], chan[0]};

`ifndef SYNTHESIS
  // input can only be held off when the whole pipe is full behind a stalled output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled while output side is free");
`endif

endmodule

// ----- bench/tb.sv -----
// Self-checking bench for the HSV to RGB stream converter.
`timescale 1ns / 100ps

module tb;

  localparam int RUN_LIMIT = 200000;  // cycles; far above the slowest correct run
  localparam int HOLD_LEN  = 60;      // receiver hold-off, in cycles, for the fill-up test
  localparam int PER_PHASE = 100;     // random transactions per idling phase

  // Input transaction, packed as on in_tdata: hue lowest, then saturation, brightness, pad.
  typedef struct packed {
    logic       pad;
    logic [6:0] bri;
    logic [6:0] sat;
    logic [8:0] hue;
  } hsv_t;

  // Result transaction, packed as on out_tdata: red lowest, then green, blue.
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  // Keeps the colors still owed by the block, oldest first.
  class rgb_scoreboard;
    rgb_t owed_rgb[$];
    int   errors;

    function new();
      errors = 0;
    endfunction

    // Scale an exact numerator over 600000 down to an 8-bit channel, truncating.
    function logic [7:0] scale_channel(int unsigned num);
      return 8'((255 * num) / 600000);
    endfunction

    // Exact integer HSV to RGB: all fractions held over the common denominator 600000.
    function rgb_t hsv_to_rgb(hsv_t px);
      int unsigned       h, s, v, rem, nv, np, nq, nt, r, g, b;
      hsvc_pkg::sector_t sec;
      rgb_t              res;
      h = px.hue;
      s = px.sat;
      v = px.bri;
      if (h >= hsvc_pkg::HUE_TURN) h = 0;     // 360 and up wrap to red
      if (s > hsvc_pkg::PCT_MAX) s = hsvc_pkg::PCT_MAX; // out-of-range percent saturates
      if (v > hsvc_pkg::PCT_MAX) v = hsvc_pkg::PCT_MAX;
      sec = hsvc_pkg::sector_t'(h / hsvc_pkg::SECTOR_DEG);
      rem = h % hsvc_pkg::SECTOR_DEG;
      nv  = v * hsvc_pkg::K_FULL;
      np  = v * (hsvc_pkg::PCT_MAX - s) * hsvc_pkg::SECTOR_DEG;
      nq  = v * (hsvc_pkg::K_FULL - s * rem);
      nt  = v * (hsvc_pkg::K_FULL - s * (hsvc_pkg::SECTOR_DEG - rem));
      case (sec)
        hsvc_pkg::SEC_0: begin r = nv; g = nt; b = np; end
        hsvc_pkg::SEC_1: begin r = nq; g = nv; b = np; end
        hsvc_pkg::SEC_2: begin r = np; g = nv; b = nt; end
        hsvc_pkg::SEC_3: begin r = np; g = nq; b = nv; end
        hsvc_pkg::SEC_4: begin r = nt; g = np; b = nv; end
        default: begin r = nv; g = np; b = nq; end
      endcase
      res.red   = scale_channel(r);
      res.green = scale_channel(g);
      res.blue  = scale_channel(b);
      return res;
    endfunction

    // Accepted input transaction: queue the color it must produce.
    function void note_pixel(hsv_t px);
      owed_rgb.push_back(hsv_to_rgb(px));
    endfunction

    // Accepted result transaction: compare with the oldest owed color.
    function void check_pixel(rgb_t got);
      rgb_t exp_rgb;
      if (owed_rgb.size() == 0) begin
        $error("unexpected result: red %0d green %0d blue %0d", got.red, got.green, got.blue);
        errors++;
        return;
      end
      exp_rgb = owed_rgb.pop_front();
      if (got.red !== exp_rgb.red) begin
        $error("red: expected %0d, got %0d", exp_rgb.red, got.red);
        errors++;
      end
      if (got.green !== exp_rgb.green) begin
        $error("green: expected %0d, got %0d", exp_rgb.green, got.green);
        errors++;
      end
      if (got.blue !== exp_rgb.blue) begin
        $error("blue: expected %0d, got %0d", exp_rgb.blue, got.blue);
        errors++;
      end
    endfunction

    function int pending();
      return owed_rgb.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;

  // Idling knobs, percent of cycles; written by the stimulus process only.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // Hold-off request from stimulus; the receiver counts the hold-off itself.
  logic hold_req = 1'b0;
  int   hold_left = 0;

  int   cycle_cnt = 0;

  rgb_scoreboard sb = new();

  hsv_to_rgb_convert dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Receiver: random stalls, or a long hold-off so the pipe fills and
  // in_tready must drop while the sender keeps offering.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left <= HOLD_LEN;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
    if (hold_req || hold_left > 1) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Result monitor. Values read here are the ones present before the edge,
  // since everything upstream updates with nonblocking assignments.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_pixel(rgb_t'(out_tdata));
    end
  end

  // Watchdog: a hang or a lost result ends the run as a failure.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > RUN_LIMIT) begin
      $display("hsv_to_rgb_convert: mismatch");
      $finish;
    end
  end

  // Offer one pixel, idling first at random, and wait for the transaction.
  // The expectation is noted at the accepting edge.
  task automatic send_pixel(input hsv_t px);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    do @(posedge clk); while (!in_tready);
    sb.note_pixel(px);
  endtask

  task automatic send_hsv(input int h, input int s, input int v);
    hsv_t px;
    px.pad = 1'b0;
    px.hue = 9'(h);
    px.sat = 7'(s);
    px.bri = 7'(v);
    send_pixel(px);
  endtask

  // Mostly legal colors; about one field in ten lands in the wrap or saturate range.
  function automatic hsv_t rand_pixel();
    hsv_t px;
    px.pad = 1'b0;
    px.hue = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(360, 511))
                                         : 9'($urandom_range(0, 359));
    px.sat = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(101, 127))
                                         : 7'($urandom_range(0, 100));
    px.bri = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(101, 127))
                                         : 7'($urandom_range(0, 100));
    return px;
  endfunction

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: sector edges, hue wrap, zero and full saturation/brightness,
    // saturating percents, all-ones fields.
    send_hsv(0, 100, 100);
    send_hsv(59, 100, 100);
    send_hsv(60, 100, 100);
    send_hsv(119, 100, 100);
    send_hsv(120, 100, 100);
    send_hsv(179, 100, 100);
    send_hsv(180, 100, 100);
    send_hsv(239, 100, 100);
    send_hsv(240, 100, 100);
    send_hsv(299, 100, 100);
    send_hsv(300, 100, 100);
    send_hsv(359, 100, 100);
    send_hsv(360, 100, 100);   // full turn wraps to red
    send_hsv(511, 127, 127);   // all-ones fields
    send_hsv(200, 0, 100);     // gray: zero saturation
    send_hsv(200, 0, 37);
    send_hsv(90, 50, 0);       // black
    send_hsv(30, 101, 100);    // saturation clamps
    send_hsv(210, 127, 101);   // both clamp
    send_hsv(330, 1, 1);
    send_hsv(45, 73, 127);
    send_hsv(0, 0, 0);

    // Random phases: no idling, sender idle, receiver stalling, both.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct <= 0;  recv_idle_pct <= 0;  end
        1: begin send_idle_pct <= 51; recv_idle_pct <= 0;  end
        2: begin send_idle_pct <= 0;  recv_idle_pct <= 51; end
        default: begin send_idle_pct <= 18; recv_idle_pct <= 18; end
      endcase
      repeat (PER_PHASE) send_pixel(rand_pixel());
    end

    // Back-pressure: receiver holds off for a long stretch while the sender
    // streams, so the pipeline fills and stalls its input.
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    hold_req <= 1'b1;
    send_pixel(rand_pixel());
    hold_req <= 1'b0;
    repeat (30) send_pixel(rand_pixel());
    in_tvalid <= 1'b0;

    // Drain, then keep clocking so any stray result shows up.
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (sb.errors == 0) begin
      $display("hsv_to_rgb_convert: match");
    end else begin
      $display("hsv_to_rgb_convert: mismatch");
    end
    $finish;
  end

endmodule
